FILE: hw/rtl/kbs_pkg.sv
// ---------------------------------------------------------------------------
// kbs_pkg: shared constants and types for the bicycle model step
// Fixed-point constants, the CORDIC arctangent table and the register map.
// ---------------------------------------------------------------------------
package kbs_pkg;

  localparam int unsigned CordicIters = 24;
  localparam int unsigned IterW       = $clog2(CordicIters + 1);

  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] TwoPiQ28  = 34'sd1686629713;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic [26:0]        Deg2RadK  = 27'd74961321;

  localparam logic signed [31:0] XReset = 32'sd2621440;
  localparam logic signed [31:0] YReset = 32'sd1966080;

  typedef enum logic [1:0] {
    RegWheelbase   = 2'd0,
    RegMaxThrottle = 2'd1,
    RegMaxSpeed    = 2'd2,
    RegTimeStep    = 2'd3
  } reg_idx_e;

  // arctangent of 2^-i in unsigned Q0.28
  function automatic logic [27:0] atan_lut(input logic [4:0] i);
    logic [27:0] r;
    unique case (i)
      5'd0:  r = 28'd210828714;
      5'd1:  r = 28'd124459457;
      5'd2:  r = 28'd65760959;
      5'd3:  r = 28'd33381290;
      5'd4:  r = 28'd16755422;
      5'd5:  r = 28'd8385879;
      5'd6:  r = 28'd4193963;
      5'd7:  r = 28'd2097109;
      5'd8:  r = 28'd1048571;
      5'd9:  r = 28'd524287;
      5'd10: r = 28'd262144;
      5'd11: r = 28'd131072;
      5'd12: r = 28'd65536;
      5'd13: r = 28'd32768;
      5'd14: r = 28'd16384;
      5'd15: r = 28'd8192;
      5'd16: r = 28'd4096;
      5'd17: r = 28'd2048;
      5'd18: r = 28'd1024;
      5'd19: r = 28'd512;
      5'd20: r = 28'd256;
      5'd21: r = 28'd128;
      5'd22: r = 28'd64;
      5'd23: r = 28'd32;
      5'd24: r = 28'd16;
      5'd25: r = 28'd8;
      5'd26: r = 28'd4;
      5'd27: r = 28'd2;
      5'd28: r = 28'd1;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  // arithmetic shift right by a runtime amount, 34-bit CORDIC datapath
  function automatic logic signed [33:0] asr34(input logic signed [33:0] v,
                                               input logic [4:0] s);
    return v >>> s;
  endfunction

endpackage

FILE: hw/rtl/kbs_cordic.sv
// ---------------------------------------------------------------------------
// kbs_cordic: shared iterative CORDIC unit
// Rotation mode (sine/cosine with quadrant folding) or vectoring mode
// (arctangent), one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module kbs_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      vector_i,
  input  logic signed [33:0]        x_i,
  input  logic signed [33:0]        y_i,
  input  logic signed [33:0]        z_i,
  output logic                      done_o,
  output logic signed [33:0]        x_o,
  output logic signed [33:0]        y_o,
  output logic signed [33:0]        z_o
);
  import kbs_pkg::*;

  logic signed [33:0] x_q, y_q, z_q;
  logic [IterW-1:0]   it_q;
  logic               busy_q, vec_q, neg_q;
  logic signed [33:0] a0, a1, xs, ys;
  logic               fold, dir;
  logic signed [33:0] at;

  always_comb begin
    a0 = z_i;
    if (a0 > PiQ28) begin
      a0 = a0 - TwoPiQ28;
    end else if (a0 < -PiQ28) begin
      a0 = a0 + TwoPiQ28;
    end
    fold = 1'b0;
    a1   = a0;
    if (a0 > HalfPiQ28) begin
      a1 = a0 - PiQ28; fold = 1'b1;
    end else if (a0 < -HalfPiQ28) begin
      a1 = a0 + PiQ28; fold = 1'b1;
    end
  end

  assign xs  = asr34(x_q, it_q[4:0]);
  assign ys  = asr34(y_q, it_q[4:0]);
  assign at  = 34'(atan_lut(it_q[4:0]));
  assign dir = vec_q ? !y_q[33] : !z_q[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
      vec_q  <= 1'b0;
      neg_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
        vec_q  <= vector_i;
        neg_q  <= vector_i ? 1'b0 : fold;
      end else if (busy_q) begin
        if (it_q == IterW'(CordicIters - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        it_q <= it_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= vector_i ? x_i : GainQ30;
      y_q <= vector_i ? y_i : '0;
      z_q <= vector_i ? '0 : a1;
    end else if (busy_q) begin
      if (vec_q) begin
        if (dir) begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
        end else begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
        end
      end else begin
        if (dir) begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
        end
      end
    end
  end

  assign x_o = neg_q ? -x_q : x_q;
  assign y_o = neg_q ? -y_q : y_q;
  assign z_o = z_q;

endmodule

FILE: hw/rtl/kbs_serdiv.sv
// ---------------------------------------------------------------------------
// kbs_serdiv: bit-serial restoring divider
// Signed 64-bit dividend by unsigned 16-bit divisor, truncating toward zero,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module kbs_serdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [15:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] q_q;
  logic [16:0] r_q;
  logic [15:0] d_q;
  logic        neg_q, busy_q;
  logic [6:0]  cnt_q;
  logic [16:0] r_sh, r_sub;

  assign r_sh  = {r_q[15:0], q_q[63]};
  assign r_sub = r_sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i[63] ? 64'(-num_i) : num_i;
      neg_q <= num_i[63];
      r_q   <= '0;
      d_q   <= (den_i == '0) ? 16'd1 : den_i;
    end else if (busy_q) begin
      if (!r_sub[16]) begin
        r_q <= r_sub;
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  assign quo_o = neg_q ? -q_q : q_q;

endmodule

FILE: hw/rtl/kinematic_bicycle_step.sv
// ---------------------------------------------------------------------------
// kinematic_bicycle_step: one tick of a kinematic single-track vehicle model
// Steering and throttle in, updated pose and speed out.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat (steer_deg_i, throttle_cmd_i) is taken when in_valid_i is high
//   and in_stall_o low. One result beat leaves on out_valid_o/out_stall_i.
//   Registers (wheelbase, throttle scale, speed scale, time step) are written
//   on cfg_valid_i & cfg_ready_o, index cfg_idx_i, only while no tick is in
//   progress; a register write holds off the input beat in that cycle.
// Sequence: a tick runs two serial divides (speed, heading increment),
//   three 24-step passes of the shared CORDIC (steer sin/cos, slip atan,
//   heading sin/cos), then sequencing and the position update. No new input
//   beat is taken until the previous tick has finished.
// Reset: pose returns to (40 m, 30 m) with zero heading, registers to
//   their defaults.
// Stall: the result beat holds in the output register while the next tick
//   is taken and computed; that tick then waits for the register to free up,
//   and no new beat is taken until it has moved on.
// ---------------------------------------------------------------------------
module kinematic_bicycle_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  steer_deg_i,
  input  logic signed [15:0]  throttle_cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [30:0]  heading_o,
  output logic signed [31:0]  speed_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import kbs_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SMul, SSpdDiv, SDelta, SCs1, SAtan, SCs2, SMove, SIncDiv, SOut
  } state_e;

  state_e state_q;
  logic [15:0] wb_q, mt_q, ms_q, dt_q;
  logic signed [31:0] x_q, y_q, yaw_q, v_q;
  logic signed [15:0] steer_q;
  logic signed [33:0] delta_q, cd_q, sd_q, ycos_hold_y;
  logic signed [63:0] prod_q;
  logic               ph_q, first_q;

  // cordic / divider handshakes
  logic cs_start, cs_vec, cs_done;
  logic signed [33:0] cs_x, cs_y, cs_z, cs_xo, cs_yo, cs_zo;
  logic dv_start, dv_done;
  logic signed [63:0] dv_num, dv_q;
  logic [15:0] dv_den;
  logic in_acc, out_free;

  kbs_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .vector_i(cs_vec),
    .x_i(cs_x), .y_i(cs_y), .z_i(cs_z),
    .done_o(cs_done), .x_o(cs_xo), .y_o(cs_yo), .z_o(cs_zo)
  );

  kbs_serdiv u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_q)
  );

  // a register write takes the idle cycle; the input beat waits for it
  assign in_stall_o  = (state_q != SIdle) | cfg_valid_i;
  assign cfg_ready_o = (state_q == SIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  // output register is free when empty or its beat leaves this cycle
  assign out_free    = ~out_valid_o | ~out_stall_i;

  // helpers, all values in range for 64-bit intermediates
  logic signed [63:0] rx, mvx, dx, sx, sy, pp, ny;

  // split the wide products: each first product is registered in prod_q
  assign rx  = (prod_q + 64'sd536870912) >>> 30;
  assign mvx = rx * $signed({48'd0, dt_q});
  assign dx  = (mvx + 64'sd32768) >>> 16;

  always_comb begin
    sx = 64'(x_q) + dx;
    sy = 64'(y_q) + dx;
  end

  assign pp = (prod_q + 64'sd536870912) >>> 30;

  always_comb begin
    ny = 64'(yaw_q) + dv_q;
    if (ny > 64'(PiQ28)) begin
      ny = ny - 64'(TwoPiQ28);
    end else if (ny < -64'(PiQ28)) begin
      ny = ny + 64'(TwoPiQ28);
    end
    // clamp a turn of more than a full circle in one tick
    if (ny > 64'(PiQ28)) ny = 64'(PiQ28);
    if (ny < -64'(PiQ28)) ny = -64'(PiQ28);
  end

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // slip vector (2 cos, sin), flipped into the right half plane
  function automatic logic signed [33:0] cvx_now(input logic signed [33:0] c,
                                                 input logic signed [33:0] s,
                                                 input logic sel);
    logic signed [33:0] a, b;
    a = 34'(c <<< 1);
    b = s;
    if (a[33]) begin
      a = -a; b = -b;
    end
    return sel ? b : a;
  endfunction

  always_comb begin
    cs_start = 1'b0; cs_vec = 1'b0;
    cs_x = '0; cs_y = '0; cs_z = '0;
    dv_start = 1'b0; dv_num = '0; dv_den = '0;
    unique case (state_q)
      SMul:   begin dv_start = 1'b1; dv_num = prod_q; dv_den = mt_q; end
      SDelta: begin cs_start = 1'b1; cs_z = delta_q; end
      SCs1:   if (cs_done) begin cs_start = 1'b1; cs_vec = 1'b1;
                cs_x = cvx_now(cs_xo, cs_yo, 1'b0); cs_y = cvx_now(cs_xo, cs_yo, 1'b1); end
      SAtan:  if (cs_done) begin cs_start = 1'b1; cs_z = 34'(yaw_q) + cs_zo; end
      SIncDiv: if (first_q) begin dv_start = 1'b1;
                dv_num = 64'(pp) * 64'(dt_q) * 64'sd16; dv_den = wb_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      wb_q        <= 16'd640;
      mt_q        <= 16'd25600;
      ms_q        <= 16'd2560;
      dt_q        <= 16'd1092;
      x_q         <= XReset;
      y_q         <= YReset;
      yaw_q       <= '0;
      out_valid_o <= 1'b0;
      first_q     <= 1'b0;
      ph_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (reg_idx_e'(cfg_idx_i))
          RegWheelbase:   wb_q <= cfg_data_i;
          RegMaxThrottle: mt_q <= cfg_data_i;
          RegMaxSpeed:    ms_q <= cfg_data_i;
          RegTimeStep:    dt_q <= cfg_data_i;
        endcase
      end
      // load a finished tick into the free output register, else drop the
      // beat once the receiver takes it
      if (state_q == SOut && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        SIdle: if (in_acc) begin
          steer_q <= steer_deg_i;
          state_q <= SMul;
          prod_q  <= 64'(throttle_cmd_i) * 64'(ms_q) * 64'sd256;
        end
        SMul: state_q <= SSpdDiv;
        SSpdDiv: if (dv_done) begin
          v_q     <= sat(dv_q);
          delta_q <= 34'((64'(steer_q) * 64'(Deg2RadK) + 64'sd2048) >>> 12);
          state_q <= SDelta;
        end
        SDelta: state_q <= SCs1;
        SCs1: if (cs_done) begin
          cd_q <= cs_xo; sd_q <= cs_yo; state_q <= SAtan;
        end
        SAtan: if (cs_done) begin
          state_q <= SCs2;
        end
        SCs2: if (cs_done) begin
          cd_q <= cs_xo; ycos_hold_y <= cs_yo;
          ph_q <= 1'b1; state_q <= SMove; first_q <= 1'b1;
        end
        SMove: begin
          if (first_q) begin
            first_q <= 1'b0;
            prod_q  <= 64'(v_q) * 64'(cd_q);
          end else if (ph_q) begin
            x_q    <= sat(sx);
            prod_q <= 64'(v_q) * 64'(ycos_hold_y);
            ph_q   <= 1'b0;
          end else begin
            y_q     <= sat(sy);
            prod_q  <= 64'(v_q) * 64'(sd_q);
            first_q <= 1'b1;
            state_q <= SIncDiv;
          end
        end
        SIncDiv: begin
          first_q <= 1'b0;
          if (dv_done) begin
            yaw_q   <= 32'(ny);
            state_q <= SOut;
          end
        end
        SOut: if (out_free) begin
          pos_x_o   <= x_q;
          pos_y_o   <= y_q;
          heading_o <= 31'(yaw_q);
          speed_o   <= v_q;
          state_q   <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
